### design/assert_macros.svh
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### design/pcee_pkg.sv
// types, codes and helper functions of the channel estimator and equalizer
package pcee_pkg;

    localparam int DW       = 16;
    localparam int IDXW     = 9;
    localparam int QW       = 16;
    localparam int Q_FRAC   = 11;
    localparam int MUL_STEPS = 6;
    localparam logic [DW-1:0] ONE_Q = 16'sd2048;

    localparam logic [2:0] RES_ZERO = 3'd0;
    localparam logic [2:0] RES_EST  = 3'd1;
    localparam logic [2:0] RES_RX   = 3'd2;
    localparam logic [2:0] RES_Q    = 3'd3;
    localparam logic [2:0] RES_AVG  = 3'd4;

    typedef struct packed {
        logic       load;
        logic       est_load;
        logic       clr_we;
        logic       mul_en;
        logic [2:0] mul_sel;
        logic       acc_en;
        logic [2:0] acc_sel;
        logic       prep;
        logic       div_step;
        logic       res_load;
        logic [2:0] res_sel;
        logic       est_we;
    } t_cmd;

    typedef struct packed {
        logic act;
        logic idx_ok;
        logic div_zero;
        logic clr_last;
    } t_sts;

    function automatic logic [DW-1:0] sat_q(input logic [QW-1:0] q, input logic neg,
                                            input logic ovf);
        logic [DW-1:0] r;
        if (ovf) begin
            r = neg ? 16'h8000 : 16'h7FFF;
        end else if (neg) begin
            r = (q > 16'd32768) ? 16'h8000 : DW'(-q);
        end else begin
            r = (q > 16'd32767) ? 16'h7FFF : q;
        end
        return r;
    endfunction

    function automatic logic [DW-1:0] avg_floor(input logic [DW-1:0] a,
                                                input logic [DW-1:0] b);
        logic [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        return s[DW:1];
    endfunction

endpackage

### design/pilot_channel_estimator_equalizer.sv
// top level of the pilot channel estimator and one-tap equalizer
// One item at a time. After reset the block sets every estimate to 1+0j and
// only then raises o_in_ready. An item whose work includes a complex division
// goes through a memory read, a decision, six passes through a single shared
// 16x16 multiplier and their accumulation, a setup step, then 16 steps of two
// radix-2 restoring dividers (real and imaginary part in parallel) before it
// reaches the result register, and no new item is accepted until then. Items
// that need no division (zero pilot, zero estimate, subcarrier out of range)
// go from the decision straight to the result register. The result waits in
// an output register, so the next item is accepted while it is still
// unclaimed.
`include "assert_macros.svh"
module pilot_channel_estimator_equalizer
    import pcee_pkg::*;
#(
    parameter int NUM_SUBCARRIERS = 512
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_action,
    input  logic [IDXW-1:0] i_subcarrier,
    input  logic [DW-1:0]   i_rx_re,
    input  logic [DW-1:0]   i_rx_im,
    input  logic [DW-1:0]   i_ref_re,
    input  logic [DW-1:0]   i_ref_im,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output logic [DW-1:0]   o_out_re,
    output logic [DW-1:0]   o_out_im
);
    t_cmd cmd;
    t_sts sts;

    pcee_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    pcee_dp #(.NUM_SUBCARRIERS(NUM_SUBCARRIERS)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_action    (i_action),
        .i_subcarrier(i_subcarrier),
        .i_rx_re     (i_rx_re),
        .i_rx_im     (i_rx_im),
        .i_ref_re    (i_ref_re),
        .i_ref_im    (i_ref_im),
        .o_out_re    (o_out_re),
        .o_out_im    (o_out_im)
    );

    `ASSERT_SYNC(a_no_overwrite, i_clk, i_rst_n, cmd.res_load |-> (!o_out_valid || i_out_ready), "result overwritten")
    `ASSERT_SYNC(a_accept_reads, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> cmd.est_load, "no memory read after accept")
    `ASSERT_SYNC(a_ready_idle, i_clk, i_rst_n, o_in_ready |-> (!cmd.mul_en && !cmd.div_step && !cmd.clr_we), "ready while busy")
    `ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> (!o_in_ready && !o_out_valid), "ready or valid right after reset")
endmodule

### design/pcee_ram.sv
// generic single-write, single-read memory with registered read data
module pcee_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### design/pcee_ctrl.sv
// controller state machine sequencing the estimator datapath
module pcee_ctrl
    import pcee_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_RD   = 3'd2;
    localparam logic [2:0] ST_DEC  = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_PREP = 3'd5;
    localparam logic [2:0] ST_DIV  = 3'd6;
    localparam logic [2:0] ST_WB   = 3'd7;

    logic [2:0] r_state, n_state;
    logic [3:0] r_cnt, n_cnt;
    logic [2:0] r_sel, n_sel;
    logic       r_out_valid, n_out_valid;
    logic       in_ready;
    t_cmd       cmd;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_sel    = r_sel;
        cmd      = '0;
        in_ready = 1'b0;
        unique case (r_state)
            ST_CLR: begin
                cmd.clr_we = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = ST_RD;
                end
            end
            ST_RD: begin
                cmd.est_load = 1'b1;
                n_state      = ST_DEC;
            end
            ST_DEC: begin
                if (!i_sts.idx_ok) begin
                    n_sel   = i_sts.act ? RES_RX : RES_ZERO;
                    n_state = ST_WB;
                end else if (i_sts.div_zero) begin
                    n_sel   = i_sts.act ? RES_RX : RES_EST;
                    n_state = ST_WB;
                end else begin
                    n_cnt   = '0;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul_en  = (r_cnt != 4'(MUL_STEPS));
                cmd.mul_sel = r_cnt[2:0];
                cmd.acc_en  = (r_cnt != 4'd0);
                cmd.acc_sel = r_cnt[2:0] - 3'd1;
                n_cnt       = r_cnt + 4'd1;
                if (r_cnt == 4'(MUL_STEPS)) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep = 1'b1;
                n_cnt    = '0;
                n_state  = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                n_cnt        = r_cnt + 4'd1;
                if (r_cnt == 4'(QW - 1)) begin
                    n_sel   = i_sts.act ? RES_Q : RES_AVG;
                    n_state = ST_WB;
                end
            end
            ST_WB: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.res_load = 1'b1;
                    cmd.est_we   = (r_sel == RES_AVG);
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
        cmd.res_sel = r_sel;
        if (cmd.res_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLR;
            r_cnt       <= '0;
            r_sel       <= RES_ZERO;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_sel       <= n_sel;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;
endmodule

### design/pcee_dp.sv
// datapath: estimate memory, shared multiplier, two radix-2 dividers, result register
module pcee_dp
    import pcee_pkg::*;
#(
    parameter int NUM_SUBCARRIERS = 512
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_cmd            i_cmd,
    output t_sts            o_sts,
    input  logic            i_action,
    input  logic [IDXW-1:0] i_subcarrier,
    input  logic [DW-1:0]   i_rx_re,
    input  logic [DW-1:0]   i_rx_im,
    input  logic [DW-1:0]   i_ref_re,
    input  logic [DW-1:0]   i_ref_im,
    output logic [DW-1:0]   o_out_re,
    output logic [DW-1:0]   o_out_im
);
    localparam int AW = $clog2(NUM_SUBCARRIERS);

    logic [AW-1:0]     r_clr_cnt;
    logic [AW-1:0]     r_addr;
    logic              r_act, r_idx_ok;
    logic [DW-1:0]     r_ar, r_ai, r_ref_re, r_ref_im, r_br, r_bi;
    logic [DW-1:0]     r_est_re, r_est_im;
    logic signed [31:0] r_prod;
    logic signed [32:0] r_den, r_nr, r_ni;
    logic [32:0]       r_rem_re, r_rem_im;
    logic [QW-1:0]     r_low_re, r_low_im, r_q_re, r_q_im;
    logic              r_neg_re, r_neg_im, r_ovf_re, r_ovf_im;
    logic [DW-1:0]     r_out_re, r_out_im;

    logic [2*DW-1:0]   ram_rdata, ram_wdata;
    logic [AW-1:0]     ram_raddr, ram_waddr;
    logic              ram_we;
    logic signed [DW-1:0] mul_x, mul_y;
    logic [32:0]       mag_re, mag_im, t_re, t_im, den_ext;
    logic [DW-1:0]     sat_re, sat_im, avg_re, avg_im;

    assign ram_raddr = i_cmd.load ? AW'(i_subcarrier) : r_addr;
    assign ram_waddr = i_cmd.clr_we ? r_clr_cnt : r_addr;
    assign ram_we    = i_cmd.clr_we || i_cmd.est_we;
    assign ram_wdata = i_cmd.clr_we ? {ONE_Q, {DW{1'b0}}} : {avg_re, avg_im};

    pcee_ram #(.WIDTH(2*DW), .DEPTH(NUM_SUBCARRIERS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        case (i_cmd.mul_sel)
            3'd0:    begin mul_x = r_br; mul_y = r_br; end
            3'd1:    begin mul_x = r_bi; mul_y = r_bi; end
            3'd2:    begin mul_x = r_ar; mul_y = r_br; end
            3'd3:    begin mul_x = r_ai; mul_y = r_bi; end
            3'd4:    begin mul_x = r_ai; mul_y = r_br; end
            default: begin mul_x = r_ar; mul_y = r_bi; end
        endcase
    end

    assign mag_re  = r_nr[32] ? 33'(-r_nr) : 33'(r_nr);
    assign mag_im  = r_ni[32] ? 33'(-r_ni) : 33'(r_ni);
    assign den_ext = {1'b0, r_den[31:0]};
    assign t_re    = {r_rem_re[31:0], r_low_re[QW-1]};
    assign t_im    = {r_rem_im[31:0], r_low_im[QW-1]};
    assign sat_re  = sat_q(r_q_re, r_neg_re, r_ovf_re);
    assign sat_im  = sat_q(r_q_im, r_neg_im, r_ovf_im);
    assign avg_re  = avg_floor(sat_re, r_est_re);
    assign avg_im  = avg_floor(sat_im, r_est_im);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
        end else if (i_cmd.clr_we) begin
            r_clr_cnt <= r_clr_cnt + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act    <= i_action;
            r_addr   <= AW'(i_subcarrier);
            r_idx_ok <= (32'(i_subcarrier) < NUM_SUBCARRIERS);
            r_ar     <= i_rx_re;
            r_ai     <= i_rx_im;
            r_ref_re <= i_ref_re;
            r_ref_im <= i_ref_im;
            r_den    <= '0;
            r_nr     <= '0;
            r_ni     <= '0;
        end
        if (i_cmd.est_load) begin
            r_est_re <= ram_rdata[2*DW-1:DW];
            r_est_im <= ram_rdata[DW-1:0];
            r_br     <= r_act ? ram_rdata[2*DW-1:DW] : r_ref_re;
            r_bi     <= r_act ? ram_rdata[DW-1:0] : r_ref_im;
        end
        if (i_cmd.mul_en) begin
            r_prod <= mul_x * mul_y;
        end
        if (i_cmd.acc_en) begin
            case (i_cmd.acc_sel)
                3'd0, 3'd1: r_den <= r_den + 33'(r_prod);
                3'd2, 3'd3: r_nr  <= r_nr + 33'(r_prod);
                3'd4:       r_ni  <= r_ni + 33'(r_prod);
                default:    r_ni  <= r_ni - 33'(r_prod);
            endcase
        end
        if (i_cmd.prep) begin
            r_neg_re <= r_nr[32];
            r_neg_im <= r_ni[32];
            r_ovf_re <= {4'b0, mag_re} >= {r_den[31:0], 5'b0};
            r_ovf_im <= {4'b0, mag_im} >= {r_den[31:0], 5'b0};
            r_rem_re <= {5'b0, mag_re[32:5]};
            r_rem_im <= {5'b0, mag_im[32:5]};
            r_low_re <= {mag_re[4:0], {Q_FRAC{1'b0}}};
            r_low_im <= {mag_im[4:0], {Q_FRAC{1'b0}}};
            r_q_re   <= '0;
            r_q_im   <= '0;
        end
        if (i_cmd.div_step) begin
            r_low_re <= {r_low_re[QW-2:0], 1'b0};
            r_low_im <= {r_low_im[QW-2:0], 1'b0};
            if (t_re >= den_ext) begin
                r_rem_re <= t_re - den_ext;
                r_q_re   <= {r_q_re[QW-2:0], 1'b1};
            end else begin
                r_rem_re <= t_re;
                r_q_re   <= {r_q_re[QW-2:0], 1'b0};
            end
            if (t_im >= den_ext) begin
                r_rem_im <= t_im - den_ext;
                r_q_im   <= {r_q_im[QW-2:0], 1'b1};
            end else begin
                r_rem_im <= t_im;
                r_q_im   <= {r_q_im[QW-2:0], 1'b0};
            end
        end
        if (i_cmd.res_load) begin
            case (i_cmd.res_sel)
                RES_EST: begin r_out_re <= r_est_re; r_out_im <= r_est_im; end
                RES_RX:  begin r_out_re <= r_ar;     r_out_im <= r_ai;     end
                RES_Q:   begin r_out_re <= sat_re;   r_out_im <= sat_im;   end
                RES_AVG: begin r_out_re <= avg_re;   r_out_im <= avg_im;   end
                default: begin r_out_re <= '0;       r_out_im <= '0;       end
            endcase
        end
    end

    assign o_sts.act      = r_act;
    assign o_sts.idx_ok   = r_idx_ok;
    assign o_sts.div_zero = (r_br == '0) && (r_bi == '0);
    assign o_sts.clr_last = (r_clr_cnt == AW'(NUM_SUBCARRIERS - 1));
    assign o_out_re       = r_out_re;
    assign o_out_im       = r_out_im;
endmodule

### tb/pilot_channel_estimator_equalizer_tb.sv
// testbench of the pilot channel estimator and one-tap equalizer
module pilot_channel_estimator_equalizer_tb
    import pcee_pkg::*;
();

    localparam int NSC = 512;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic ACT_UPDATE = 1'b0;
    localparam logic ACT_EQUALIZE = 1'b1;

    typedef struct {
        logic [DW-1:0] re;
        logic [DW-1:0] im;
    } t_cplx;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_in_valid;
    logic            o_in_ready;
    logic            i_action;
    logic [IDXW-1:0] i_subcarrier;
    logic [DW-1:0]   i_rx_re;
    logic [DW-1:0]   i_rx_im;
    logic [DW-1:0]   i_ref_re;
    logic [DW-1:0]   i_ref_im;
    logic            o_out_valid;
    logic            i_out_ready;
    logic [DW-1:0]   o_out_re;
    logic [DW-1:0]   o_out_im;

    pilot_channel_estimator_equalizer #(.NUM_SUBCARRIERS(NSC)) dut (.*);

    int est_re [NSC];
    int est_im [NSC];
    t_cplx expected_q[$];
    int error_count;
    int idle_cycles;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_off;
    bit timed_out;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int quot_sat(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag * 2048) / den;
        if (num < 0) return (q > 32768) ? -32768 : -int'(q);
        return (q > 32767) ? 32767 : int'(q);
    endfunction

    function automatic void cplx_div(int ar, int ai, int br, int bi, output int qr,
                                     output int qi);
        longint den;
        den = longint'(br) * br + longint'(bi) * bi;
        qr = quot_sat(longint'(ar) * br + longint'(ai) * bi, den);
        qi = quot_sat(longint'(ai) * br - longint'(ar) * bi, den);
    endfunction

    function automatic t_cplx estimate_or_equalize(logic act, logic [IDXW-1:0] sc,
                                                   logic [DW-1:0] rr, logic [DW-1:0] ri,
                                                   logic [DW-1:0] pr, logic [DW-1:0] pi);
        int ar, ai, br, bi, hr, hi, er, ei;
        t_cplx r;
        ar = $signed(rr);
        ai = $signed(ri);
        br = $signed(pr);
        bi = $signed(pi);
        r.re = rr;
        r.im = ri;
        if (act == ACT_UPDATE) begin
            if (sc >= NSC) begin
                r.re = '0;
                r.im = '0;
            end else begin
                if (br != 0 || bi != 0) begin
                    cplx_div(ar, ai, br, bi, hr, hi);
                    est_re[sc] = (hr + est_re[sc] + 65536) / 2 - 32768;
                    est_im[sc] = (hi + est_im[sc] + 65536) / 2 - 32768;
                end
                r.re = DW'(est_re[sc]);
                r.im = DW'(est_im[sc]);
            end
        end else if (sc < NSC) begin
            er = est_re[sc];
            ei = est_im[sc];
            if (er != 0 || ei != 0) begin
                cplx_div(ar, ai, er, ei, hr, hi);
                r.re = DW'(hr);
                r.im = DW'(hi);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [DW-1:0] got, logic [DW-1:0] want);
        error_count++;
        $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
    endtask

    task automatic send_item(logic act, logic [IDXW-1:0] sc, logic [DW-1:0] rr,
                             logic [DW-1:0] ri, logic [DW-1:0] pr, logic [DW-1:0] pi);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action <= act;
        i_subcarrier <= sc;
        i_rx_re <= rr;
        i_rx_im <= ri;
        i_ref_re <= pr;
        i_ref_im <= pi;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_q.push_back(estimate_or_equalize(act, sc, rr, ri, pr, pi));
    endtask

    // receiver side
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready && i_rst_n) begin
            if (expected_q.size() == 0) begin
                error_count++;
                $display("unexpected result %0d %0d", $signed(o_out_re), $signed(o_out_im));
            end else begin
                t_cplx e;
                e = expected_q.pop_front();
                if (o_out_re !== e.re) report_mismatch("out_re", o_out_re, e.re);
                if (o_out_im !== e.im) report_mismatch("out_im", o_out_im, e.im);
            end
        end
        i_out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [DW-1:0] rand_sample();
        case ($urandom_range(5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return DW'($urandom_range(4095)) - 16'd2048;
            default: return DW'($urandom);
        endcase
    endfunction

    function automatic logic [IDXW-1:0] rand_subcarrier();
        return ($urandom_range(3) == 0) ? IDXW'($urandom) : IDXW'($urandom_range(15));
    endfunction

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_item(ACT_EQUALIZE, 9'd0, 16'h7FFF, 16'h8000, '0, '0);
        send_item(ACT_UPDATE, 9'd1, 16'h1000, 16'h0000, '0, '0);
        send_item(ACT_UPDATE, 9'd1, 16'h1000, 16'h0800, 16'h0800, 16'h0000);
        send_item(ACT_EQUALIZE, 9'd1, 16'h0800, 16'h0800, '0, '0);
        send_item(ACT_UPDATE, 9'd2, 16'h7FFF, 16'h7FFF, 16'h0001, 16'h0000);
        send_item(ACT_UPDATE, 9'd3, 16'h8000, 16'h8000, 16'h0000, 16'h0001);
        send_item(ACT_UPDATE, 9'd4, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_item(ACT_UPDATE, 9'd5, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        send_item(ACT_EQUALIZE, 9'd2, 16'h7FFF, 16'h8000, '0, '0);
        // drive an estimate to zero: rx = 0 against pilot, repeatedly
        for (int k = 0; k < 14; k++) send_item(ACT_UPDATE, 9'd6, '0, '0, 16'h0800, '0);
        send_item(ACT_EQUALIZE, 9'd6, 16'h1234, 16'hFEDC, '0, '0);
        send_item(ACT_UPDATE, 9'd511, 16'h0800, 16'h0800, 16'h0800, 16'h0000);
        send_item(ACT_EQUALIZE, 9'd511, 16'h0400, 16'hFC00, '0, '0);
    endtask

    task automatic test_random(int count);
        for (int k = 0; k < count; k++) begin
            logic [DW-1:0] pr, pi;
            pr = rand_sample();
            pi = rand_sample();
            if ($urandom_range(9) == 0) begin
                pr = '0;
                pi = '0;
            end
            send_item(logic'($urandom_range(1)), rand_subcarrier(), rand_sample(),
                      rand_sample(), pr, pi);
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_off = 1'b0;
            end
            test_random(12);
        join
    endtask

    initial begin
        error_count = 0;
        idle_cycles = 0;
        timed_out = 1'b0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int k = 0; k < NSC; k++) begin
            est_re[k] = 2048;
            est_im[k] = 0;
        end
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_ready = 1'b0;
        i_action = 1'b0;
        i_subcarrier = '0;
        i_rx_re = '0;
        i_rx_im = '0;
        i_ref_re = '0;
        i_ref_im = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(370);
        send_idle_pct = 66;
        test_random(370);
        send_idle_pct = 0;
        recv_stall_pct = 66;
        test_random(370);
        send_idle_pct = 12;
        recv_stall_pct = 12;
        test_random(370);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        test_backpressure();
        wait_drained();
        if (error_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

### filelist.f
+incdir+design
design/pcee_pkg.sv
design/pcee_ram.sv
design/pcee_ctrl.sv
design/pcee_dp.sv
design/pilot_channel_estimator_equalizer.sv
tb/pilot_channel_estimator_equalizer_tb.sv
